// ===== rtl/core/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler:
// table size, task slot record, input mode codes and sequencer states.
// ----------------------------------------------------------------------------
package srtf_pkg;

   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [15:0] task_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remain;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/srtf_ram.sv =====
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srtf_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top
// Preemptive shortest-remaining-time-first scheduler over a table of task
// slots. Load and clear transactions are done when accepted. A tick
// transaction scans the slot RAM, reading one slot per cycle, then passes
// a finish state that registers its result strobe; the next transaction is
// taken in the cycle the strobe shows. The receiver cannot stall. Reset
// clears the slot valid bits and the clock; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_top
   import srtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_task_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_time,
   output logic        rsp_valid,
   output logic [31:0] rsp_tick_time,
   output logic        rsp_ran,
   output logic [15:0] rsp_running_id,
   output logic        rsp_finished,
   output logic [31:0] rsp_completion_time,
   output logic [31:0] rsp_turnaround_time,
   output logic [31:0] rsp_waiting_time,
   output logic        rsp_all_done
);

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     loaded_ff, loaded_in;
   logic [31:0]          clock_ff, clock_in;
   logic [CNT_W-1:0]     addr_ff, addr_in;
   logic                 dvld_ff, dvld_in;
   logic [SLOT_W-1:0]    didx_ff, didx_in;
   logic                 found_ff, found_in;
   logic [1:0]           open_ff, open_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            best_ff, best_in;
   logic [SLOT_W-1:0]    best_idx_ff, best_idx_in;

   logic [31:0] rsp_tick_ff, rsp_tick_in;
   logic        rsp_ran_ff, rsp_ran_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic        rsp_fin_ff, rsp_fin_in;
   logic [31:0] rsp_comp_ff, rsp_comp_in;
   logic [31:0] rsp_tat_ff, rsp_tat_in;
   logic [31:0] rsp_wt_ff, rsp_wt_in;
   logic        rsp_done_ff, rsp_done_in;

   logic              accept;
   mode_type          mode;
   logic              slot_ok;
   logic [SLOT_W-1:0] slot_idx;
   logic              issue;
   logic              scan_last;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;

   logic              cand_open;
   logic              cand_elig;
   logic              cand_better;

   logic [31:0]       next_clk;
   logic [15:0]       new_remain;
   logic [31:0]       tat;

   assign accept    = start && !busy;
   assign mode      = mode_type'(req_mode);
   assign slot_ok   = 32'(req_slot) < SLOTS;
   assign slot_idx  = SLOT_W'(req_slot);
   assign issue     = (state_ff == ST_SCAN) && (32'(addr_ff) < SLOTS);
   assign scan_last = dvld_ff && (didx_ff == SLOT_W'(SLOTS - 1));

   srtf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (issue),
      .rd_addr (addr_ff[SLOT_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign cand_open   = loaded_ff[didx_ff] && (ram_rdata.remain != 16'd0);
   assign cand_elig   = cand_open && (32'(ram_rdata.arrival) <= clock_ff);
   assign cand_better = !found_ff || (ram_rdata.remain < best_ff.remain) ||
                        ((ram_rdata.remain == best_ff.remain) &&
                         (ram_rdata.arrival < best_ff.arrival));

   assign next_clk   = (clock_ff == 32'hFFFF_FFFF) ? clock_ff : clock_ff + 32'd1;
   assign new_remain = best_ff.remain - 16'd1;
   assign tat        = (next_clk >= 32'(best_ff.arrival)) ?
                       next_clk - 32'(best_ff.arrival) : 32'd0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (mode == MODE_TICK)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      loaded_in    = loaded_ff;
      clock_in     = clock_ff;
      addr_in      = addr_ff;
      dvld_in      = issue;
      didx_in      = addr_ff[SLOT_W-1:0];
      found_in     = found_ff;
      open_in      = open_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = slot_idx;
      ram_wdata    = '{task_id: req_task_id, arrival: req_arrival_time,
                       burst: req_burst_time, remain: req_burst_time};
      rsp_tick_in  = clock_ff;
      rsp_ran_in   = 1'b0;
      rsp_id_in    = 16'd0;
      rsp_fin_in   = 1'b0;
      rsp_comp_in  = 32'd0;
      rsp_tat_in   = 32'd0;
      rsp_wt_in    = 32'd0;
      rsp_done_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (mode)
                  MODE_LOAD: begin
                     if (slot_ok) begin
                        ram_we              = 1'b1;
                        loaded_in[slot_idx] = 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     loaded_in = '0;
                     clock_in  = 32'd0;
                  end
                  MODE_TICK: begin
                     addr_in  = '0;
                     found_in = 1'b0;
                     open_in  = 2'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end
            if (dvld_ff) begin
               if (cand_open && (open_ff != 2'd2)) begin
                  open_in = open_ff + 2'd1;
               end
               if (cand_elig && cand_better) begin
                  found_in    = 1'b1;
                  best_in     = ram_rdata;
                  best_idx_in = didx_ff;
               end
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (open_ff == 2'd0) begin
               rsp_done_in = 1'b1;
            end else begin
               clock_in = next_clk;
               if (found_ff) begin
                  ram_we           = 1'b1;
                  ram_waddr        = best_idx_ff;
                  ram_wdata        = best_ff;
                  ram_wdata.remain = new_remain;
                  rsp_ran_in       = 1'b1;
                  rsp_id_in        = best_ff.task_id;
                  if (new_remain == 16'd0) begin
                     rsp_fin_in  = 1'b1;
                     rsp_comp_in = next_clk;
                     rsp_tat_in  = tat;
                     rsp_wt_in   = (tat >= 32'(best_ff.burst)) ?
                                   tat - 32'(best_ff.burst) : 32'd0;
                     rsp_done_in = (open_ff == 2'd1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         clock_ff     <= 32'd0;
         addr_ff      <= '0;
         dvld_ff      <= 1'b0;
         found_ff     <= 1'b0;
         open_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         clock_ff     <= clock_in;
         addr_ff      <= addr_in;
         dvld_ff      <= dvld_in;
         found_ff     <= found_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff     <= didx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (state_ff == ST_FINISH) begin
         rsp_tick_ff <= rsp_tick_in;
         rsp_ran_ff  <= rsp_ran_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_fin_ff  <= rsp_fin_in;
         rsp_comp_ff <= rsp_comp_in;
         rsp_tat_ff  <= rsp_tat_in;
         rsp_wt_ff   <= rsp_wt_in;
         rsp_done_ff <= rsp_done_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tick_time       = rsp_tick_ff;
   assign rsp_ran             = rsp_ran_ff;
   assign rsp_running_id      = rsp_id_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_completion_time = rsp_comp_ff;
   assign rsp_turnaround_time = rsp_tat_ff;
   assign rsp_waiting_time    = rsp_wt_ff;
   assign rsp_all_done        = rsp_done_ff;

endmodule

// ===== tb/sv/srtf_tick_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// srtf_tick_scheduler_top_tb
// Self-checking bench for the shortest-remaining-time-first tick scheduler.
// A short table of load, tick, clear and unused-mode transactions covers
// field extremes, tie breaks, zero burst, idle and all-done ticks, then
// random load/tick/clear sequences run under three sender idle profiles.
// Every tick result is compared field by field with the report given in its
// table row, or else with an in-bench model of the slot table and scheduler clock.
// ----------------------------------------------------------------------------
module srtf_tick_scheduler_top_tb;
   import srtf_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DIRECTED_N  = 25;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic [31:0] tick_time;
      logic        ran;
      logic [15:0] running_id;
      logic        finished;
      logic [31:0] completion_time;
      logic [31:0] turnaround_time;
      logic [31:0] waiting_time;
      logic        all_done;
   } tick_report_type;

   typedef struct packed {
      mode_type        mode;
      logic [3:0]      slot;
      logic [15:0]     task_id;
      logic [15:0]     arrival;
      logic [15:0]     burst;
      logic            typed;
      tick_report_type report;
   } directed_row_type;

   localparam tick_report_type NO_REPORT = '0;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [3:0]  req_slot;
   logic [15:0] req_task_id;
   logic [15:0] req_arrival_time;
   logic [15:0] req_burst_time;
   logic        rsp_valid;
   logic [31:0] rsp_tick_time;
   logic        rsp_ran;
   logic [15:0] rsp_running_id;
   logic        rsp_finished;
   logic [31:0] rsp_completion_time;
   logic [31:0] rsp_turnaround_time;
   logic [31:0] rsp_waiting_time;
   logic        rsp_all_done;

   logic        task_present [SLOTS];
   logic [15:0] task_ident   [SLOTS];
   logic [15:0] task_arrival [SLOTS];
   logic [15:0] task_burst   [SLOTS];
   logic [15:0] task_remain  [SLOTS];
   logic [31:0] sched_time;

   tick_report_type  expected_reports [$];
   directed_row_type directed_rows [DIRECTED_N];

   int idle_pct    = 21;
   int item_count  = 0;
   int fail_count  = 0;
   int cycle_count = 0;

   srtf_tick_scheduler_top dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_slot            (req_slot),
      .req_task_id         (req_task_id),
      .req_arrival_time    (req_arrival_time),
      .req_burst_time      (req_burst_time),
      .rsp_valid           (rsp_valid),
      .rsp_tick_time       (rsp_tick_time),
      .rsp_ran             (rsp_ran),
      .rsp_running_id      (rsp_running_id),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround_time (rsp_turnaround_time),
      .rsp_waiting_time    (rsp_waiting_time),
      .rsp_all_done        (rsp_all_done)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("srtf_tick_scheduler_top: mismatch");
         $finish;
      end
   end

   function automatic bit all_tasks_done();
      for (int i = 0; i < SLOTS; i++)
         if (task_present[i] && task_remain[i] != 16'd0)
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void schedule_step(input mode_type mode, input logic [3:0] slot,
                                         input logic [15:0] id, input logic [15:0] arr,
                                         input logic [15:0] bst, output bit produced,
                                         output tick_report_type rep);
      int          pick;
      logic [31:0] t0;
      logic [31:0] arr32;
      logic [31:0] tat;
      pick     = -1;
      produced = 1'b0;
      rep      = '0;
      case (mode)
         MODE_LOAD: begin
            task_present[slot] = 1'b1;
            task_ident[slot]   = id;
            task_arrival[slot] = arr;
            task_burst[slot]   = bst;
            task_remain[slot]  = bst;
         end
         MODE_CLEAR: begin
            for (int i = 0; i < SLOTS; i++)
               task_present[i] = 1'b0;
            sched_time = '0;
         end
         MODE_TICK: begin
            produced      = 1'b1;
            t0            = sched_time;
            rep.tick_time = t0;
            if (all_tasks_done()) begin
               rep.all_done = 1'b1;
               return;
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!task_present[i] || task_remain[i] == 16'd0)
                  continue;
               if ({16'h0, task_arrival[i]} > t0)
                  continue;
               if (pick < 0 || task_remain[i] < task_remain[pick] ||
                   (task_remain[i] == task_remain[pick] &&
                    task_arrival[i] < task_arrival[pick]))
                  pick = i;
            end
            sched_time = (t0 == 32'hFFFF_FFFF) ? t0 : t0 + 32'd1;
            if (pick >= 0) begin
               rep.ran        = 1'b1;
               rep.running_id = task_ident[pick];
               task_remain[pick] = task_remain[pick] - 16'd1;
               if (task_remain[pick] == 16'd0) begin
                  arr32 = {16'h0, task_arrival[pick]};
                  tat   = (sched_time >= arr32) ? sched_time - arr32 : 32'd0;
                  rep.finished        = 1'b1;
                  rep.completion_time = sched_time;
                  rep.turnaround_time = tat;
                  rep.waiting_time    = (tat >= {16'h0, task_burst[pick]}) ?
                                        tat - {16'h0, task_burst[pick]} : 32'd0;
               end
            end
            rep.all_done = all_tasks_done();
         end
         default: ;
      endcase
   endfunction

   function automatic logic [15:0] random_arrival();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return 16'($urandom);
      if (r < 4)
         return 16'($urandom_range(0, 3));
      return sched_time[15:0] + 16'($urandom_range(0, 6));
   endfunction

   function automatic logic [15:0] random_burst();
      if ($urandom_range(0, 15) == 0)
         return 16'($urandom_range(1, 65535));
      return 16'($urandom_range(1, 6));
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         report_failure($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   task automatic issue(input mode_type mode, input logic [3:0] slot, input logic [15:0] id,
                        input logic [15:0] arr, input logic [15:0] bst, input bit typed,
                        input tick_report_type typed_rep);
      bit              produced;
      tick_report_type rep;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_mode         <= mode;
      req_slot         <= slot;
      req_task_id      <= id;
      req_arrival_time <= arr;
      req_burst_time   <= bst;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      schedule_step(mode, slot, id, arr, bst, produced, rep);
      if (produced)
         expected_reports.insert(expected_reports.size(), typed ? typed_rep : rep);
      if (mode != MODE_NONE)
         item_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      tick_report_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_reports.size() == 0) begin
            report_failure("result strobe with no tick transaction pending");
         end else begin
            want = expected_reports.pop_front();
            check_field("tick_time", want.tick_time, rsp_tick_time);
            check_field("ran", 32'(want.ran), 32'(rsp_ran));
            check_field("running_id", 32'(want.running_id), 32'(rsp_running_id));
            check_field("finished", 32'(want.finished), 32'(rsp_finished));
            check_field("completion_time", want.completion_time, rsp_completion_time);
            check_field("turnaround_time", want.turnaround_time, rsp_turnaround_time);
            check_field("waiting_time", want.waiting_time, rsp_waiting_time);
            check_field("all_done", 32'(want.all_done), 32'(rsp_all_done));
         end
      end
   end

   initial begin : stimulus
      int               goal;
      int               r;
      directed_row_type row;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_mode         <= MODE_NONE;
      req_slot         <= '0;
      req_task_id      <= '0;
      req_arrival_time <= '0;
      req_burst_time   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
         task_present[i] = 1'b0;
         task_ident[i]   = '0;
         task_arrival[i] = '0;
         task_burst[i]   = '0;
         task_remain[i]  = '0;
      end
      sched_time = '0;

      directed_rows = '{
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd0, 1'b0, 16'h0000, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1}},
         '{MODE_NONE,  4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd0,  16'hFFFF, 16'h0000, 16'h0001, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd15, 16'h0000, 16'h0000, 16'h0002, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd0, 1'b1, 16'hFFFF, 1'b1, 32'd1, 32'd1, 32'd0, 1'b0}},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd1, 1'b1, 16'h0000, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd2, 1'b1, 16'h0000, 1'b1, 32'd3, 32'd3, 32'd1, 1'b1}},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd3, 1'b0, 16'h0000, 1'b0, 32'd0, 32'd0, 32'd0, 1'b1}},
         '{MODE_CLEAR, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd5,  16'h1234, 16'h0003, 16'h0002, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{32'd0, 1'b0, 16'h0000, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0}},
         '{MODE_LOAD,  4'd3,  16'hAAAA, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd7,  16'h5555, 16'h0000, 16'hFFFF, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd9,  16'h9999, 16'h0001, 16'h0003, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd8,  16'h00F0, 16'h0001, 16'h0003, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd2,  16'h0F0F, 16'h0002, 16'h0003, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd8,  16'h00F0, 16'h0001, 16'h0003, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_LOAD,  4'd12, 16'hC3C3, 16'hFFFF, 16'h0005, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT},
         '{MODE_CLEAR, 4'd0,  16'h0000, 16'h0000, 16'h0000, 1'b0, NO_REPORT}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         row = directed_rows[i];
         issue(row.mode, row.slot, row.task_id, row.arrival, row.burst, row.typed, row.report);
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 21 : (phase == 1) ? 88 : 0;
         goal     = item_count + PHASE_ITEMS;
         while (item_count < goal) begin
            if ($urandom_range(0, 3) != 0)
               issue(MODE_CLEAR, 4'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'b0, NO_REPORT);
            repeat ($urandom_range(1, 6))
               issue(MODE_LOAD, 4'($urandom), 16'($urandom), random_arrival(),
                     random_burst(), 1'b0, NO_REPORT);
            for (int t = 0; t < 60; t++) begin
               if (item_count >= goal)
                  break;
               if (all_tasks_done() && $urandom_range(0, 2) == 0)
                  break;
               r = $urandom_range(0, 19);
               if (r == 0)
                  issue(MODE_NONE, 4'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 1'b0, NO_REPORT);
               else if (r == 1)
                  issue(MODE_LOAD, 4'($urandom), 16'($urandom), random_arrival(),
                        random_burst(), 1'b0, NO_REPORT);
               issue(MODE_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 1'b0, NO_REPORT);
            end
         end
      end

      start <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (SLOTS + 4) @(posedge clock);

      if (fail_count == 0) begin
         $display("srtf_tick_scheduler_top: match");
      end else begin
         $display("srtf_tick_scheduler_top: mismatch");
      end
      $finish;
   end

endmodule
